// ===== design/mavgx_pkg.sv =====
// shared constants and types for the moving average crossover block
package mavgx_pkg;

    localparam int PRICE_W   = 32;
    localparam int IDX_W     = 32;
    localparam int WIN_W     = 7;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = ((2 + IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_W - 2 - IDX_W;

    localparam int DEF_DEPTH = 64;
    localparam logic [WIN_W-1:0] DEF_SHORT = WIN_W'(20);
    localparam logic [WIN_W-1:0] DEF_LONG  = WIN_W'(50);

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        REL_BELOW = 2'd0,
        REL_EQUAL = 2'd1,
        REL_ABOVE = 2'd2
    } rel_t;

    typedef struct packed {
        logic advance;
        logic push;
        logic restart;
    } ring_ctrl_t;

endpackage

// ===== design/mavgx_ring.sv =====
// price history ring: one write port, two registered read ports, fill tracking
module mavgx_ring #(
    parameter int HISTORY_DEPTH = mavgx_pkg::DEF_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mavgx_pkg::ring_ctrl_t                 ctrl,
    input  logic [mavgx_pkg::PRICE_W-1:0]         price,
    input  logic [mavgx_pkg::WIN_W-1:0]           short_len,
    input  logic [mavgx_pkg::WIN_W-1:0]           long_len,
    output logic [mavgx_pkg::PRICE_W-1:0]         old_short,
    output logic [mavgx_pkg::PRICE_W-1:0]         old_long
);
    import mavgx_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic [PRICE_W-1:0] mem [HISTORY_DEPTH];

    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      wp_next;
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      fill_next;
    logic [AW-1:0]      addr_short;
    logic [AW-1:0]      addr_long;
    logic [PRICE_W-1:0] rd_short_reg;
    logic [PRICE_W-1:0] rd_long_reg;
    logic               ok_short_reg;
    logic               ok_long_reg;

    function automatic logic [AW-1:0] back_addr(logic [AW-1:0] wp, logic [WIN_W-1:0] len);
        logic [AW:0] lenx;
        logic [AW:0] wrapped;
        lenx    = (AW+1)'(len);
        wrapped = {1'b0, wp} + (AW+1)'(HISTORY_DEPTH) - lenx;
        if ({1'b0, wp} >= lenx)
            return AW'({1'b0, wp} - lenx);
        else
            return AW'(wrapped);
    endfunction

    always_comb
    begin
        addr_short = back_addr(wp_reg, short_len);
        addr_long  = back_addr(wp_reg, long_len);
        wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
        fill_next  = (fill_reg == FW'(HISTORY_DEPTH)) ? fill_reg : fill_reg + FW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wp_reg] <= price;
        end
        if (ctrl.advance)
        begin
            rd_short_reg <= mem[addr_short];
            rd_long_reg  <= mem[addr_long];
            ok_short_reg <= fill_reg >= FW'(short_len);
            ok_long_reg  <= fill_reg >= FW'(long_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.restart)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.push)
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // slots never written since restart read as zero
    assign old_short = ok_short_reg ? rd_short_reg : '0;
    assign old_long  = ok_long_reg  ? rd_long_reg  : '0;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(HISTORY_DEPTH))
        else $error("fill count above ring depth");

    a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg < AW'(HISTORY_DEPTH - 1) || wp_reg == AW'(HISTORY_DEPTH - 1))
        else $error("write pointer outside ring");

    a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FW'(HISTORY_DEPTH) |-> FW'(wp_reg) == fill_reg)
        else $error("write pointer and fill count disagree during warm-up");

endmodule

// ===== design/moving_average_crossover.sv =====
// moving average crossover: top level with sum, cross-multiply and compare pipeline
// ring read, sum update, cross-multiply, then compare into the output register;
// throughput one sample per cycle while the skid stage is empty, set by the two read ports
// of the history ring and the running-sum update
// reset (and any window write) clears sums, counters and ring fill count at once;
// no clearing pass, stale ring slots read as zero until rewritten
module moving_average_crossover #(
    parameter int HISTORY_DEPTH = mavgx_pkg::DEF_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mavgx_pkg::PRICE_W-1:0]         s_tdata,   // price
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mavgx_pkg::OUT_W-1:0]           m_tdata,   // buy, sell, sample_index, zero pad
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mavgx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mavgx_pkg::WIN_W-1:0]           cfg_data
);
    import mavgx_pkg::*;

    localparam int MAX_WIN = (HISTORY_DEPTH < (1 << WIN_W) - 1) ? HISTORY_DEPTH : (1 << WIN_W) - 1;
    localparam int SUM_W   = PRICE_W + $clog2(MAX_WIN);
    localparam int PROD_W  = SUM_W + WIN_W;

    logic [WIN_W-1:0]   short_win_reg;
    logic [WIN_W-1:0]   long_win_reg;
    logic [WIN_W-1:0]   s_eff;
    logic [WIN_W-1:0]   l_eff;
    logic               restart;
    logic               advance;
    logic               take;
    ring_ctrl_t         ring_ctrl;
    logic [PRICE_W-1:0] old_short;
    logic [PRICE_W-1:0] old_long;

    logic [IDX_W-1:0]   sample_count_reg;
    logic               v1_reg;
    logic [PRICE_W-1:0] price1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic               v2_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic [SUM_W-1:0]   short_sum_reg;
    logic [SUM_W-1:0]   long_sum_reg;
    logic [SUM_W-1:0]   short_sum_next;
    logic [SUM_W-1:0]   long_sum_next;
    logic               v3_reg;
    logic [IDX_W-1:0]   idx3_reg;
    logic [PROD_W-1:0]  lhs_reg;
    logic [PROD_W-1:0]  rhs_reg;

    rel_t               rel;
    rel_t               prev_rel_reg;
    logic               armed_reg;
    logic               armed_now;
    logic               buy;
    logic               sell;
    logic               emit;

    logic               out_valid_reg;
    logic               out_buy_reg;
    logic               out_sell_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic               skid_valid_reg;
    logic               skid_buy_reg;
    logic               skid_sell_reg;
    logic [IDX_W-1:0]   skid_idx_reg;

    function automatic logic [WIN_W-1:0] eff_window(logic [WIN_W-1:0] w);
        if (w == '0)
            return WIN_W'(1);
        else if (int'(w) > HISTORY_DEPTH)
            return WIN_W'(HISTORY_DEPTH);
        else
            return w;
    endfunction

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index == REG_SHORT_WINDOW ||
                                     cfg_index == REG_LONG_WINDOW);
    assign s_eff     = eff_window(short_win_reg);
    assign l_eff     = eff_window(long_win_reg);

    // the whole pipeline moves unless the skid stage holds a result
    assign advance   = !skid_valid_reg;
    assign s_tready  = advance;
    assign take      = s_tvalid && advance;

    assign ring_ctrl = '{advance: advance, push: take, restart: restart};

    mavgx_ring #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ring_ctrl),
        .price    (s_tdata),
        .short_len(s_eff),
        .long_len (l_eff),
        .old_short(old_short),
        .old_long (old_long)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_win_reg <= DEF_SHORT;
            long_win_reg  <= DEF_LONG;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SHORT_WINDOW: short_win_reg <= cfg_data;
                REG_LONG_WINDOW:  long_win_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        short_sum_next = short_sum_reg + SUM_W'(price1_reg) - SUM_W'(old_short);
        long_sum_next  = long_sum_reg  + SUM_W'(price1_reg) - SUM_W'(old_long);
    end

    always_comb
    begin
        if (lhs_reg > rhs_reg)
            rel = REL_ABOVE;
        else if (lhs_reg < rhs_reg)
            rel = REL_BELOW;
        else
            rel = REL_EQUAL;
        armed_now = armed_reg || (idx3_reg >= IDX_W'(l_eff));
        buy       = armed_now && (rel == REL_ABOVE) && (prev_rel_reg != REL_ABOVE);
        sell      = armed_now && (rel == REL_BELOW) && (prev_rel_reg != REL_BELOW);
        emit      = v3_reg && advance;
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            price1_reg <= s_tdata;
            idx1_reg   <= sample_count_reg;
            idx2_reg   <= idx1_reg;
            idx3_reg   <= idx2_reg;
            lhs_reg    <= PROD_W'(short_sum_reg) * PROD_W'(l_eff);
            rhs_reg    <= PROD_W'(long_sum_reg)  * PROD_W'(s_eff);
        end
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            short_sum_reg    <= '0;
            long_sum_reg     <= '0;
            armed_reg        <= 1'b0;
            prev_rel_reg     <= REL_EQUAL;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
        end
        else if (restart)
        begin
            sample_count_reg <= '0;
            short_sum_reg    <= '0;
            long_sum_reg     <= '0;
            armed_reg        <= 1'b0;
            prev_rel_reg     <= REL_EQUAL;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (take)
            begin
                sample_count_reg <= sample_count_reg + IDX_W'(1);
            end
            if (v1_reg)
            begin
                short_sum_reg <= short_sum_next;
                long_sum_reg  <= long_sum_next;
            end
            if (v3_reg)
            begin
                armed_reg    <= armed_now;
                prev_rel_reg <= rel;
            end
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (emit)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_buy_reg  <= skid_buy_reg;
                out_sell_reg <= skid_sell_reg;
                out_idx_reg  <= skid_idx_reg;
            end
            else
            begin
                out_buy_reg  <= buy;
                out_sell_reg <= sell;
                out_idx_reg  <= idx3_reg;
            end
        end
        else if (emit)
        begin
            skid_buy_reg  <= buy;
            skid_sell_reg <= sell;
            skid_idx_reg  <= idx3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_reg, out_sell_reg, out_buy_reg};

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid stage filled without a stalled output");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_buy_reg && out_sell_reg))
        else $error("buy and sell raised together");

    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg && !restart |=> armed_reg)
        else $error("armed dropped without a restart");

endmodule
